FILE: hw/rtl/nwue_pkg.sv
package nwue_pkg;

  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int RATE_W     = 31;
  localparam int STEP_W     = 22;
  localparam int PROD_W     = 64;
  localparam int FRAC_W     = 16;
  localparam int QPROD_W    = PROD_W - FRAC_W;
  localparam int SUM_W      = 50;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [STEP_W-1:0]  STEP_DEFAULT = 22'd6554;
  localparam logic [STEP_W-1:0]  MAX_DEFAULT  = 22'd3276800;
  localparam logic [STEP_W-1:0]  STEP_MIN     = 22'd1;
  localparam logic [16:0]        ETA_PLUS     = 17'd78643;
  localparam logic [PROD_W-1:0]  ROUND_HALF   = 64'd32768;
  localparam logic [RATE_W-1:0]  LEARN_RESET  = 31'd6554;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_t;

  typedef enum logic {
    MODE_GD    = 1'b0,
    MODE_RPROP = 1'b1
  } mode_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          weight_index;
    logic signed [DATA_W-1:0]  load_value;
    logic signed [DATA_W-1:0]  gradient;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic signed [DATA_W-1:0]  new_weight;
    logic signed [DATA_W-1:0]  step_taken;
  } result_t;

  // saturate a wide signed sum to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // Q16.16 product rounding: floor((p + 0.5 LSB) / 2^16)
  function automatic logic signed [QPROD_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + $signed(ROUND_HALF);
    return t[PROD_W-1:FRAC_W];
  endfunction

endpackage

FILE: hw/rtl/nwue_stream_if.sv
interface nwue_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/nn_weight_update_engine_top.sv
// Channel   Dir  Handshake       Payload
// item      in   valid/ready     func, weight_index, load_value, gradient
// result    out  valid/ready     out_index, new_weight, step_taken
// apb       in   psel/penable    6 config registers at paddr 4*i, 32-bit data
//
// One item per cycle for distinct weights while the FIFO has room; a result passes
// stages A to D into the result FIFO. The store is a registered-read memory; an item
// whose weight is in the 4-stage read-modify-write pipe waits until it is written back.
// Results queue in an 8-entry FIFO; item.ready drops when in-flight plus queued reach 8.
// Synchronous reset sets the registers to defaults; the store is not cleared.
module nn_weight_update_engine_top #(
  parameter int WEIGHT_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nwue_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nwue_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nwue_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  nwue_stream_if.sink                         item,
  nwue_stream_if.source                       result
);

  localparam int ADDR_W     = $clog2(WEIGHT_COUNT);
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int OCC_W      = CNT_W + 1;

  localparam int DW = nwue_pkg::DATA_W;
  localparam int SW = nwue_pkg::STEP_W;
  localparam int IW = nwue_pkg::IDX_W;
  localparam int PW = nwue_pkg::PROD_W;
  localparam int QW = nwue_pkg::QPROD_W;
  localparam int XW = nwue_pkg::SUM_W;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_LEARN_RATE = 3'd1,
    REG_MOMENTUM   = 3'd2,
    REG_DECAY      = 3'd3,
    REG_MAX_STEP   = 3'd4,
    REG_INIT_STEP  = 3'd5
  } reg_sel_t;

  typedef struct packed {
    logic signed [DW-1:0] weight;
    logic signed [DW-1:0] last_step;
    logic [SW-1:0]        step_size;
  } entry_t;

  // ---------------- configuration ----------------
  nwue_pkg::mode_t                update_mode;
  logic [nwue_pkg::RATE_W-1:0]    learn_rate;
  logic [nwue_pkg::RATE_W-1:0]    momentum;
  logic [nwue_pkg::RATE_W-1:0]    decay_rate;
  logic [SW-1:0]                  max_step;
  logic [SW-1:0]                  initial_step;
  logic [SW-1:0]                  max_eff;
  logic [SW-1:0]                  init_pick;
  logic [SW-1:0]                  init_eff;
  logic                           cfg_wr;
  reg_sel_t                       reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_sel_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode  <= nwue_pkg::MODE_GD;
      learn_rate   <= nwue_pkg::LEARN_RESET;
      momentum     <= '0;
      decay_rate   <= '0;
      max_step     <= nwue_pkg::MAX_DEFAULT;
      initial_step <= nwue_pkg::STEP_DEFAULT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MODE:       update_mode  <= nwue_pkg::mode_t'(pwdata[0]);
        REG_LEARN_RATE: learn_rate   <= pwdata[nwue_pkg::RATE_W-1:0];
        REG_MOMENTUM:   momentum     <= pwdata[nwue_pkg::RATE_W-1:0];
        REG_DECAY:      decay_rate   <= pwdata[nwue_pkg::RATE_W-1:0];
        REG_MAX_STEP:   max_step     <= pwdata[SW-1:0];
        REG_INIT_STEP:  initial_step <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:       prdata = {31'd0, update_mode};
      REG_LEARN_RATE: prdata = {1'b0, learn_rate};
      REG_MOMENTUM:   prdata = {1'b0, momentum};
      REG_DECAY:      prdata = {1'b0, decay_rate};
      REG_MAX_STEP:   prdata = {10'd0, max_step};
      REG_INIT_STEP:  prdata = {10'd0, initial_step};
      default:        prdata = '0;
    endcase
  end

  // zero selects the default, and the start step never exceeds the limit
  assign max_eff   = (max_step != '0) ? max_step : nwue_pkg::MAX_DEFAULT;
  assign init_pick = (initial_step != '0) ? initial_step : nwue_pkg::STEP_DEFAULT;
  assign init_eff  = (init_pick > max_eff) ? max_eff : init_pick;

  // ---------------- pipeline control ----------------
  logic a_valid, b_valid, c_valid, d_valid;
  logic [IW-1:0] a_idx, b_idx, c_idx, d_idx;
  logic [IW-1:0] in_idx;
  logic          hit;
  logic          accept;
  logic          in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  fifo_cnt;
  logic [OCC_W-1:0]  occupancy;

  assign in_idx   = item.data.weight_index;
  assign in_range = 32'(in_idx) < 32'(WEIGHT_COUNT);
  assign rd_addr  = ADDR_W'(in_idx);

  // same-weight interlock: entry must be written back before it is read again
  assign hit = (a_valid && a_idx == in_idx) || (b_valid && b_idx == in_idx) ||
               (c_valid && c_idx == in_idx) || (d_valid && d_idx == in_idx);

  assign occupancy = OCC_W'(a_valid) + OCC_W'(b_valid) + OCC_W'(c_valid) +
                     OCC_W'(d_valid) + OCC_W'(fifo_cnt);

  assign item.ready = !hit && (occupancy < OCC_W'(FIFO_DEPTH));
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // ---------------- weight store ----------------
  entry_t            mem [WEIGHT_COUNT];
  entry_t            rd_entry;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // ---------------- stage A: multiply ----------------
  nwue_pkg::func_t      a_func;
  logic                 a_in_range;
  logic signed [DW-1:0] a_load, a_grad;

  always_ff @(posedge clk) begin
    a_func     <= item.data.func;
    a_idx      <= in_idx;
    a_in_range <= in_range;
    a_load     <= item.data.load_value;
    a_grad     <= item.data.gradient;
  end

  nwue_pkg::func_t      b_func;
  logic                 b_in_range;
  logic signed [DW-1:0] b_load, b_grad, b_w, b_last;
  logic [SW-1:0]        b_s;
  logic signed [PW-1:0] b_p_lr, b_p_mom, b_p_wd;

  always_ff @(posedge clk) begin
    b_func     <= a_func;
    b_idx      <= a_idx;
    b_in_range <= a_in_range;
    b_load     <= a_load;
    b_grad     <= a_grad;
    b_w        <= rd_entry.weight;
    b_last     <= rd_entry.last_step;
    b_s        <= rd_entry.step_size;
    b_p_lr     <= PW'($signed({1'b0, learn_rate})) * PW'(a_grad);
    b_p_mom    <= PW'($signed({1'b0, momentum})) * PW'(rd_entry.last_step);
    b_p_wd     <= PW'($signed({1'b0, decay_rate})) * PW'(rd_entry.weight);
  end

  // ---------------- stage B: round, step size candidates ----------------
  logic [39:0]   s_grow_prod;
  logic [23:0]   s_grow;
  logic [SW-1:0] s_up, s_dn;
  logic [SW:0]   s_inc;

  always_comb begin
    s_grow_prod = 40'(b_s) * 40'(nwue_pkg::ETA_PLUS) + 40'(nwue_pkg::ROUND_HALF);
    s_grow      = s_grow_prod[39:16];
    s_up        = (s_grow > 24'(max_eff)) ? max_eff : s_grow[SW-1:0];
    // halving with round-half-up is (s + 1) / 2
    s_inc       = {1'b0, b_s} + 23'd1;
    s_dn        = (s_inc[SW:1] == '0) ? nwue_pkg::STEP_MIN : s_inc[SW:1];
  end

  nwue_pkg::func_t      c_func;
  logic                 c_in_range;
  logic signed [DW-1:0] c_load, c_grad, c_w, c_last;
  logic [SW-1:0]        c_s, c_s_up, c_s_dn;
  logic signed [QW-1:0] c_q_lr, c_q_mom, c_q_wd;

  always_ff @(posedge clk) begin
    c_func     <= b_func;
    c_idx      <= b_idx;
    c_in_range <= b_in_range;
    c_load     <= b_load;
    c_grad     <= b_grad;
    c_w        <= b_w;
    c_last     <= b_last;
    c_s        <= b_s;
    c_s_up     <= s_up;
    c_s_dn     <= s_dn;
    c_q_lr     <= nwue_pkg::qround(b_p_lr);
    c_q_mom    <= nwue_pkg::qround(b_p_mom);
    c_q_wd     <= nwue_pkg::qround(b_p_wd);
  end

  // ---------------- stage C: descent step, decayed gradient ----------------
  nwue_pkg::func_t      d_func;
  logic                 d_in_range;
  logic signed [DW-1:0] d_load, d_w, d_last, d_gd_step, d_e;
  logic [SW-1:0]        d_s, d_s_up, d_s_dn;

  always_ff @(posedge clk) begin
    d_func     <= c_func;
    d_idx      <= c_idx;
    d_in_range <= c_in_range;
    d_load     <= c_load;
    d_w        <= c_w;
    d_last     <= c_last;
    d_s        <= c_s;
    d_s_up     <= c_s_up;
    d_s_dn     <= c_s_dn;
    d_gd_step  <= nwue_pkg::sat32(XW'(c_q_mom) - XW'(c_q_lr) - XW'(c_q_wd));
    d_e        <= nwue_pkg::sat32(XW'(c_grad) + XW'(c_q_wd));
  end

  // ---------------- stage D: step, weight, write back ----------------
  logic                 last_nz, e_nz, flip, agree, step_neg;
  logic [SW-1:0]        s_new;
  logic [DW-1:0]        step_mag;
  logic signed [DW-1:0] step, w_new;
  nwue_pkg::result_t    res;

  always_comb begin
    last_nz  = d_last != '0;
    e_nz     = d_e != '0;
    flip     = last_nz && e_nz && (d_last[DW-1] != d_e[DW-1]);
    agree    = last_nz && e_nz && (d_last[DW-1] == d_e[DW-1]);
    s_new    = d_s;
    step_neg = !d_e[DW-1];
    if (flip) begin
      s_new = d_s_up;
    end else if (agree) begin
      s_new = d_s_dn;
    end
    step_mag = (agree || !e_nz) ? '0 : DW'(s_new);
    // move against the decayed gradient
    step     = step_neg ? -$signed(step_mag) : $signed(step_mag);
    if (update_mode == nwue_pkg::MODE_GD) begin
      step  = d_gd_step;
      s_new = d_s;
    end
    w_new = nwue_pkg::sat32(XW'(d_w) + XW'(step));

    wr_en   = d_valid && d_in_range;
    wr_addr = ADDR_W'(d_idx);
    if (d_func == nwue_pkg::FUNC_LOAD) begin
      wr_entry = '{weight: d_load, last_step: '0, step_size: init_eff};
    end else begin
      wr_entry = '{weight: w_new, last_step: step, step_size: s_new};
    end

    res.out_index = d_idx;
    if (!d_in_range) begin
      res.new_weight = '0;
      res.step_taken = '0;
    end else if (d_func == nwue_pkg::FUNC_LOAD) begin
      res.new_weight = d_load;
      res.step_taken = '0;
    end else begin
      res.new_weight = w_new;
      res.step_taken = step;
    end
  end

  // ---------------- result FIFO ----------------
  nwue_pkg::result_t fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic              pop;

  assign pop          = result.valid && result.ready;
  assign result.valid = fifo_cnt != '0;
  assign result.data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (d_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (d_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_W'(d_valid) - CNT_W'(pop);
    end
  end

endmodule
